// File: rtl/core/lspf_pkg.sv
// Shared types, constants and helper functions for the least-squares parabola fit.
// Used by lspf_ctrl, lspf_dp and least_squares_parabola_fit; no dependencies.
package lspf_pkg;

   localparam int MAX_POINTS = 256;
   localparam int CNT_W      = 9;
   localparam int X_W        = 12;
   localparam int Y_W        = 16;
   localparam int COEF_W     = 32;
   localparam int MOP_W      = 24;
   localparam int PROD_W     = 2 * MOP_W;
   localparam int SX_W       = 20;
   localparam int SXX_W      = 31;
   localparam int SX3_W      = 42;
   localparam int SX4_W      = 53;
   localparam int SY_W       = 24;
   localparam int SXY_W      = 35;
   localparam int SX2Y_W     = 46;
   localparam int ENTRY_W    = 64;
   localparam int WIDE_W     = 128;
   localparam int MEM_DEPTH  = 12;
   localparam int ADDR_W     = 4;
   localparam int BIT_CNT_W  = 7;
   localparam int STEP_W     = 4;

   localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(WIDE_W - 1);
   localparam logic [ADDR_W-1:0]    FILL_LAST = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(8);
   localparam logic [1:0]           RHS_COL   = 2'd3;
   localparam logic [1:0]           DET_K     = 2'd3;
   localparam logic [1:0]           LAST_K    = 2'd2;

   typedef struct packed {
      logic signed [X_W-1:0] x_value;
      logic signed [Y_W-1:0] y_value;
      logic                  last_point;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
      logic                     singular;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PT_XX, ST_PT_XY, ST_PT_X3, ST_PT_X4, ST_PT_X2Y, ST_FILL,
      ST_MUL_READ, ST_MUL_LOAD, ST_MUL_RUN, ST_MUL_ACC, ST_DET_CHECK,
      ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_DONE, ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      DP_IDLE, DP_LATCH, DP_PT_XX, DP_PT_XY, DP_PT_X3, DP_PT_X4, DP_PT_X2Y,
      DP_FILL, DP_MUL_READ, DP_MUL_LOAD, DP_MUL_STEP, DP_MUL_ACC, DP_DET_SAVE,
      DP_DIV_LOAD, DP_DIV_STEP, DP_DIV_DONE, DP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      MODE_T_SET, MODE_T_SUB, MODE_ACC_SET, MODE_ACC_SUB, MODE_ACC_ADD
   } acc_mode_type;

   typedef struct packed {
      logic [1:0]   a_row;
      logic [1:0]   a_col;
      logic [1:0]   b_row;
      logic [1:0]   b_col;
      logic         use_t;
      acc_mode_type mode;
   } mul_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [ADDR_W-1:0] fill_addr;
      logic              clear_sums;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              use_t;
      acc_mode_type      mode;
      logic [1:0]        col_k;
   } cmd_type;

   typedef struct packed {
      logic last_point;
      logic acc_zero;
      logic rsp_full;
   } stat_type;

   // Cofactor expansion of a 3x3 determinant along row 0, one product per step.
   function automatic mul_op_type mul_op(input logic [STEP_W-1:0] step);
      mul_op_type o;
      o = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b0, MODE_T_SET};
      case (step)
         4'd0:    o = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b0, MODE_T_SET};
         4'd1:    o = '{2'd1, 2'd2, 2'd2, 2'd1, 1'b0, MODE_T_SUB};
         4'd2:    o = '{2'd0, 2'd0, 2'd0, 2'd0, 1'b1, MODE_ACC_SET};
         4'd3:    o = '{2'd1, 2'd0, 2'd2, 2'd2, 1'b0, MODE_T_SET};
         4'd4:    o = '{2'd1, 2'd2, 2'd2, 2'd0, 1'b0, MODE_T_SUB};
         4'd5:    o = '{2'd0, 2'd1, 2'd0, 2'd0, 1'b1, MODE_ACC_SUB};
         4'd6:    o = '{2'd1, 2'd0, 2'd2, 2'd1, 1'b0, MODE_T_SET};
         4'd7:    o = '{2'd1, 2'd1, 2'd2, 2'd0, 1'b0, MODE_T_SUB};
         4'd8:    o = '{2'd0, 2'd2, 2'd0, 2'd0, 1'b1, MODE_ACC_ADD};
         default: o = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b0, MODE_T_SET};
      endcase
      return o;
   endfunction

   // Matrix entry address; column k is replaced by the right-hand side.
   function automatic logic [ADDR_W-1:0] mat_addr(input logic [1:0] row,
                                                   input logic [1:0] col,
                                                   input logic [1:0] k);
      logic [1:0] c;
      c = (col == k) ? RHS_COL : col;
      return {row, c};
   endfunction

endpackage

// File: rtl/core/lspf_ctrl.sv
// Sequencer for the parabola fit: point accumulation, matrix fill, determinant
// products, divisions and result hand-off. Depends on lspf_pkg.
module lspf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lspf_pkg::stat_type stat,
   output lspf_pkg::cmd_type  cmd
);

   lspf_pkg::state_type state_ff, state_in;
   logic [lspf_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [1:0]                     k_ff, k_in;
   logic [lspf_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [lspf_pkg::ADDR_W-1:0]    fill_ff, fill_in;
   lspf_pkg::mul_op_type           mop;

   assign mop = lspf_pkg::mul_op(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lspf_pkg::ST_IDLE;
         step_ff  <= '0;
         k_ff     <= lspf_pkg::DET_K;
         cnt_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         fill_ff  <= fill_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      fill_in  = fill_ff;
      req_stall = reset || (state_ff != lspf_pkg::ST_IDLE);

      cmd.op         = lspf_pkg::DP_IDLE;
      cmd.fill_addr  = fill_ff;
      cmd.clear_sums = 1'b0;
      cmd.rd_addr_a  = lspf_pkg::mat_addr(mop.a_row, mop.a_col, k_ff);
      cmd.rd_addr_b  = lspf_pkg::mat_addr(mop.b_row, mop.b_col, k_ff);
      cmd.use_t      = mop.use_t;
      cmd.mode       = mop.mode;
      cmd.col_k      = k_ff;

      case (state_ff)
         lspf_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.op   = lspf_pkg::DP_LATCH;
               state_in = lspf_pkg::ST_PT_XX;
            end
         end
         lspf_pkg::ST_PT_XX: begin
            cmd.op   = lspf_pkg::DP_PT_XX;
            state_in = lspf_pkg::ST_PT_XY;
         end
         lspf_pkg::ST_PT_XY: begin
            cmd.op   = lspf_pkg::DP_PT_XY;
            state_in = lspf_pkg::ST_PT_X3;
         end
         lspf_pkg::ST_PT_X3: begin
            cmd.op   = lspf_pkg::DP_PT_X3;
            state_in = lspf_pkg::ST_PT_X4;
         end
         lspf_pkg::ST_PT_X4: begin
            cmd.op   = lspf_pkg::DP_PT_X4;
            state_in = lspf_pkg::ST_PT_X2Y;
         end
         lspf_pkg::ST_PT_X2Y: begin
            cmd.op  = lspf_pkg::DP_PT_X2Y;
            fill_in = '0;
            state_in = stat.last_point ? lspf_pkg::ST_FILL : lspf_pkg::ST_IDLE;
         end
         lspf_pkg::ST_FILL: begin
            cmd.op  = lspf_pkg::DP_FILL;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == lspf_pkg::FILL_LAST) begin
               cmd.clear_sums = 1'b1;
               step_in  = '0;
               k_in     = lspf_pkg::DET_K;
               state_in = lspf_pkg::ST_MUL_READ;
            end
         end
         lspf_pkg::ST_MUL_READ: begin
            cmd.op   = lspf_pkg::DP_MUL_READ;
            state_in = lspf_pkg::ST_MUL_LOAD;
         end
         lspf_pkg::ST_MUL_LOAD: begin
            cmd.op   = lspf_pkg::DP_MUL_LOAD;
            cnt_in   = '0;
            state_in = lspf_pkg::ST_MUL_RUN;
         end
         lspf_pkg::ST_MUL_RUN: begin
            cmd.op = lspf_pkg::DP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lspf_pkg::BIT_LAST) begin
               state_in = lspf_pkg::ST_MUL_ACC;
            end
         end
         lspf_pkg::ST_MUL_ACC: begin
            cmd.op = lspf_pkg::DP_MUL_ACC;
            if (step_ff == lspf_pkg::STEP_LAST) begin
               step_in  = '0;
               state_in = (k_ff == lspf_pkg::DET_K) ? lspf_pkg::ST_DET_CHECK
                                                     : lspf_pkg::ST_DIV_LOAD;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = lspf_pkg::ST_MUL_READ;
            end
         end
         lspf_pkg::ST_DET_CHECK: begin
            cmd.op = lspf_pkg::DP_DET_SAVE;
            k_in   = 2'd0;
            state_in = stat.acc_zero ? lspf_pkg::ST_EMIT : lspf_pkg::ST_MUL_READ;
         end
         lspf_pkg::ST_DIV_LOAD: begin
            cmd.op   = lspf_pkg::DP_DIV_LOAD;
            cnt_in   = '0;
            state_in = lspf_pkg::ST_DIV_RUN;
         end
         lspf_pkg::ST_DIV_RUN: begin
            cmd.op = lspf_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lspf_pkg::BIT_LAST) begin
               state_in = lspf_pkg::ST_DIV_DONE;
            end
         end
         lspf_pkg::ST_DIV_DONE: begin
            cmd.op = lspf_pkg::DP_DIV_DONE;
            if (k_ff == lspf_pkg::LAST_K) begin
               state_in = lspf_pkg::ST_EMIT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = lspf_pkg::ST_MUL_READ;
            end
         end
         lspf_pkg::ST_EMIT: begin
            cmd.op = lspf_pkg::DP_EMIT;
            // hold until the output register is free
            if (!stat.rsp_full) begin
               state_in = lspf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lspf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/lspf_dp.sv
// Datapath of the parabola fit: moment sums, matrix store, bit-serial 128-bit
// multiplier and divider, output register. Depends on lspf_pkg.
module lspf_dp (
   input  logic               clock,
   input  logic               reset,
   input  lspf_pkg::req_type  req_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output lspf_pkg::rsp_type  rsp_data,
   input  lspf_pkg::cmd_type  cmd,
   output lspf_pkg::stat_type stat
);

   localparam int W  = lspf_pkg::WIDE_W;
   localparam int EW = lspf_pkg::ENTRY_W;

   // point registers
   logic signed [lspf_pkg::X_W-1:0]   x_ff;
   logic signed [lspf_pkg::Y_W-1:0]   y_ff;
   logic signed [lspf_pkg::MOP_W-1:0] x2_ff;
   logic                              last_ff;
   logic                              en_ff;

   // moment sums
   logic [lspf_pkg::CNT_W-1:0]          count_ff;
   logic signed [lspf_pkg::SX_W-1:0]    sum_x_ff;
   logic [lspf_pkg::SXX_W-1:0]          sum_x_sq_ff;
   logic signed [lspf_pkg::SX3_W-1:0]   sum_x_cube_ff;
   logic [lspf_pkg::SX4_W-1:0]          sum_x_quad_ff;
   logic signed [lspf_pkg::SY_W-1:0]    sum_y_ff;
   logic signed [lspf_pkg::SXY_W-1:0]   sum_xy_ff;
   logic signed [lspf_pkg::SX2Y_W-1:0]  sum_x_sq_y_ff;

   logic signed [lspf_pkg::MOP_W-1:0]  pa, pb;
   logic signed [lspf_pkg::PROD_W-1:0] prod;

   // matrix store
   logic [EW-1:0] mat_mem [lspf_pkg::MEM_DEPTH];
   logic [EW-1:0] rd_a_ff, rd_b_ff;
   logic [EW-1:0] fill_val;
   logic [1:0]    fill_row, fill_col;
   logic [2:0]    msel;

   // wide arithmetic
   logic [W-1:0] mul_a_ff, mul_b_ff, prod_ff, t_ff, acc_ff, det_ff;
   logic [W-1:0] num, num_mag, den_mag;
   logic [W-1:0] div_n_ff, div_q_ff, den_ff;
   logic [W:0]   div_r_ff, r_shift;
   logic         r_ge, neg_ff, round_up;
   logic [W:0]   q_round, limit, mag;
   logic [lspf_pkg::COEF_W-1:0] coef_val;
   logic [lspf_pkg::COEF_W-1:0] coef_ff [3];
   logic                        sing_ff;
   logic                        rsp_valid_ff;
   lspf_pkg::rsp_type           rsp_data_ff;

   // point products through one multiplier
   always_comb begin
      pa = lspf_pkg::MOP_W'(x_ff);
      pb = lspf_pkg::MOP_W'(y_ff);
      case (cmd.op)
         lspf_pkg::DP_PT_XX: begin
            pa = lspf_pkg::MOP_W'(x_ff);
            pb = lspf_pkg::MOP_W'(x_ff);
         end
         lspf_pkg::DP_PT_X3: begin
            pa = x2_ff;
            pb = lspf_pkg::MOP_W'(x_ff);
         end
         lspf_pkg::DP_PT_X4: begin
            pa = x2_ff;
            pb = x2_ff;
         end
         lspf_pkg::DP_PT_X2Y: begin
            pa = x2_ff;
            pb = lspf_pkg::MOP_W'(y_ff);
         end
         default: begin
            pa = lspf_pkg::MOP_W'(x_ff);
            pb = lspf_pkg::MOP_W'(y_ff);
         end
      endcase
   end

   assign prod = lspf_pkg::PROD_W'(pa) * lspf_pkg::PROD_W'(pb);

   always_ff @(posedge clock) begin
      if (cmd.op == lspf_pkg::DP_LATCH) begin
         x_ff    <= req_data.x_value;
         y_ff    <= req_data.y_value;
         last_ff <= req_data.last_point;
         en_ff   <= (count_ff < lspf_pkg::CNT_W'(lspf_pkg::MAX_POINTS));
      end
      if (cmd.op == lspf_pkg::DP_PT_XX) begin
         x2_ff <= prod[lspf_pkg::MOP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         count_ff      <= '0;
         sum_x_ff      <= '0;
         sum_x_sq_ff   <= '0;
         sum_x_cube_ff <= '0;
         sum_x_quad_ff <= '0;
         sum_y_ff      <= '0;
         sum_xy_ff     <= '0;
         sum_x_sq_y_ff <= '0;
      end else if (en_ff) begin
         case (cmd.op)
            lspf_pkg::DP_PT_XX: begin
               count_ff <= count_ff + 1'b1;
               sum_x_ff <= sum_x_ff + lspf_pkg::SX_W'(x_ff);
               sum_y_ff <= sum_y_ff + lspf_pkg::SY_W'(y_ff);
            end
            lspf_pkg::DP_PT_XY: begin
               sum_xy_ff <= sum_xy_ff + lspf_pkg::SXY_W'(prod);
            end
            lspf_pkg::DP_PT_X3: begin
               sum_x_cube_ff <= sum_x_cube_ff + lspf_pkg::SX3_W'(prod);
            end
            lspf_pkg::DP_PT_X4: begin
               sum_x_quad_ff <= sum_x_quad_ff + lspf_pkg::SX4_W'($unsigned(prod));
            end
            lspf_pkg::DP_PT_X2Y: begin
               sum_x_sq_y_ff <= sum_x_sq_y_ff + lspf_pkg::SX2Y_W'(prod);
               sum_x_sq_ff   <= sum_x_sq_ff + lspf_pkg::SXX_W'($unsigned(x2_ff));
            end
            default: begin
            end
         endcase
      end
   end

   // entry (row, col) of the normal matrix is moment row+col; column 3 is the rhs
   assign fill_row = cmd.fill_addr[3:2];
   assign fill_col = cmd.fill_addr[1:0];
   assign msel     = {1'b0, fill_row} + {1'b0, fill_col};

   always_comb begin
      fill_val = EW'(sum_x_quad_ff);
      if (fill_col == lspf_pkg::RHS_COL) begin
         case (fill_row)
            2'd0:    fill_val = EW'(sum_y_ff);
            2'd1:    fill_val = EW'(sum_xy_ff);
            default: fill_val = EW'(sum_x_sq_y_ff);
         endcase
      end else begin
         case (msel)
            3'd0:    fill_val = EW'(count_ff);
            3'd1:    fill_val = EW'(sum_x_ff);
            3'd2:    fill_val = EW'(sum_x_sq_ff);
            3'd3:    fill_val = EW'(sum_x_cube_ff);
            default: fill_val = EW'(sum_x_quad_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lspf_pkg::DP_FILL) begin
         mat_mem[cmd.fill_addr] <= fill_val;
      end
      rd_a_ff <= mat_mem[cmd.rd_addr_a];
      rd_b_ff <= mat_mem[cmd.rd_addr_b];
   end

   // shift-add multiplier, products kept modulo 2^128
   always_ff @(posedge clock) begin
      case (cmd.op)
         lspf_pkg::DP_MUL_LOAD: begin
            mul_a_ff <= {{(W-EW){rd_a_ff[EW-1]}}, rd_a_ff};
            mul_b_ff <= cmd.use_t ? t_ff : {{(W-EW){rd_b_ff[EW-1]}}, rd_b_ff};
            prod_ff  <= '0;
         end
         lspf_pkg::DP_MUL_STEP: begin
            if (mul_b_ff[0]) begin
               prod_ff <= prod_ff + mul_a_ff;
            end
            mul_a_ff <= {mul_a_ff[W-2:0], 1'b0};
            mul_b_ff <= {1'b0, mul_b_ff[W-1:1]};
         end
         lspf_pkg::DP_MUL_ACC: begin
            case (cmd.mode)
               lspf_pkg::MODE_T_SET:   t_ff   <= prod_ff;
               lspf_pkg::MODE_T_SUB:   t_ff   <= t_ff - prod_ff;
               lspf_pkg::MODE_ACC_SET: acc_ff <= prod_ff;
               lspf_pkg::MODE_ACC_SUB: acc_ff <= acc_ff - prod_ff;
               lspf_pkg::MODE_ACC_ADD: acc_ff <= acc_ff + prod_ff;
               default:                t_ff   <= prod_ff;
            endcase
         end
         default: begin
         end
      endcase
   end

   // numerator scaled to Q16 for a, Q16 for b, Q16 for c from Q8, Q4, Q0 moments
   always_comb begin
      case (cmd.col_k)
         2'd0:    num = acc_ff << 8;
         2'd1:    num = acc_ff << 12;
         default: num = acc_ff << 16;
      endcase
   end

   assign num_mag = num[W-1] ? (~num + 1'b1) : num;
   assign den_mag = det_ff[W-1] ? (~det_ff + 1'b1) : det_ff;
   assign r_shift = {div_r_ff[W-1:0], div_n_ff[W-1]};
   assign r_ge    = (r_shift >= {1'b0, den_ff});

   // round half away from zero, then saturate the magnitude
   assign round_up = ({div_r_ff, 1'b0} >= {2'b00, den_ff});
   assign q_round  = {1'b0, div_q_ff} + (W+1)'(round_up);
   assign limit    = neg_ff ? (W+1)'(33'h0_8000_0000) : (W+1)'(33'h0_7FFF_FFFF);
   assign mag      = (q_round > limit) ? limit : q_round;
   assign coef_val = neg_ff ? (~mag[lspf_pkg::COEF_W-1:0] + 1'b1)
                            : mag[lspf_pkg::COEF_W-1:0];

   always_ff @(posedge clock) begin
      case (cmd.op)
         lspf_pkg::DP_DET_SAVE: begin
            det_ff     <= acc_ff;
            sing_ff    <= (acc_ff == '0);
            coef_ff[0] <= '0;
            coef_ff[1] <= '0;
            coef_ff[2] <= '0;
         end
         lspf_pkg::DP_DIV_LOAD: begin
            div_n_ff <= num_mag;
            den_ff   <= den_mag;
            div_r_ff <= '0;
            div_q_ff <= '0;
            neg_ff   <= num[W-1] ^ det_ff[W-1];
         end
         lspf_pkg::DP_DIV_STEP: begin
            div_r_ff <= r_ge ? (r_shift - {1'b0, den_ff}) : r_shift;
            div_n_ff <= {div_n_ff[W-2:0], 1'b0};
            div_q_ff <= {div_q_ff[W-2:0], r_ge};
         end
         lspf_pkg::DP_DIV_DONE: begin
            coef_ff[cmd.col_k] <= coef_val;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == lspf_pkg::DP_EMIT && !stat.rsp_full) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == lspf_pkg::DP_EMIT && !stat.rsp_full) begin
         rsp_data_ff.coef_a   <= coef_ff[0];
         rsp_data_ff.coef_b   <= coef_ff[1];
         rsp_data_ff.coef_c   <= coef_ff[2];
         rsp_data_ff.singular <= sing_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign stat.last_point = last_ff;
   assign stat.acc_zero   = (acc_ff == '0);
   assign stat.rsp_full   = rsp_valid_ff & rsp_stall;

endmodule

// File: rtl/core/least_squares_parabola_fit.sv
// Top level of the least-squares parabola fit: sequencer plus datapath.
// Depends on lspf_pkg, lspf_ctrl and lspf_dp.
//
//   channel  ports                          payload
//   req      req_valid, req_stall, req_data  x_value, y_value, last_point
//   rsp      rsp_valid, rsp_stall, rsp_data  coef_a, coef_b, coef_c, singular
//
// A point is latched, then its five products pass one by one through the shared
// 24x24 multiplier; no new point is taken until they are done. A point marked
// last adds a fill of the 12 matrix entries and the solve: 36 products and 3
// divisions on the one-bit-per-cycle 128-bit multiplier and divider.
// A singular set skips the 27 numerator products and the divisions.
// Reset clears the sums, the count and the output valid. A stalled result is
// held in the output register while the next points are taken.
module least_squares_parabola_fit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lspf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lspf_pkg::rsp_type rsp_data
);

   lspf_pkg::cmd_type  cmd;
   lspf_pkg::stat_type stat;

   lspf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lspf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
